// File: rtl/rlfg_pkg.sv
package rlfg_pkg;

  localparam int COUNT_W = 13;
  localparam int SHOT_W  = 9;
  localparam int PCT_W   = 7;
  localparam int GRADE_W = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [1:0] REG_MAX_BAD_RUN      = 2'd0;
  localparam logic [1:0] REG_MAX_BAD_CHAN_PCT = 2'd1;
  localparam logic [1:0] REG_MAX_BAD_LINE_PCT = 2'd2;

  localparam logic [COUNT_W-1:0] RST_MAX_BAD_RUN      = 13'd3;
  localparam logic [PCT_W-1:0]   RST_MAX_BAD_CHAN_PCT = 7'd10;
  localparam logic [PCT_W-1:0]   RST_MAX_BAD_LINE_PCT = 7'd10;

  localparam logic [GRADE_W-1:0] GRADE_GOOD   = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_NORMAL = 2'd1;
  localparam logic [GRADE_W-1:0] GRADE_BAD    = 2'd2;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_SHOT = 1'b1;

  typedef struct packed {
    logic resistance_fault;
    logic tilt_fault;
    logic leakage_fault;
    logic seismic_channel;
    logic end_of_line;
    logic end_of_shot;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic               line_passed;
    logic               run_limit_hit;
    logic               share_limit_hit;
    logic [COUNT_W-1:0] bad_channels;
    logic [COUNT_W-1:0] line_channels;
    logic [GRADE_W-1:0] shot_grade;
    logic [SHOT_W-1:0]  failed_lines;
    logic [SHOT_W-1:0]  graded_lines;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] max_bad_run;
    logic [PCT_W-1:0]   max_bad_chan_pct;
    logic [PCT_W-1:0]   max_bad_line_pct;
  } cfg_t;

  typedef struct packed {
    logic line_v;
    logic shot_v;
    out_t line_res;
    out_t shot_res;
  } push_t;

endpackage

// File: rtl/receiver_line_fault_grader.sv
// receiver line fault grader
// in_ channel: one channel test record per beat (in_valid / in_stall); records
// come grouped by receiver line with end_of_line and end_of_shot marks.
// out_ channel: line verdicts and shot grades, one per beat (out_valid /
// out_stall); an end_of_shot record gives the line verdict, if any, then the grade.
// apb port: registers max_bad_run at 0x0, max_bad_channel_percent at 0x4,
// max_bad_line_percent at 0x8; pready is always high, reads return the value.
// throughput: one record per cycle while in_stall is low; counters and percent cross-multiplies
// update in the accepting cycle, results go to a four-entry output queue.
// a result is written into the output queue as its record is accepted.
// an end_of_shot record can put two results in the queue, which drains at one
// per cycle while out_stall is low, so a long run of such records is paced by the output channel.
// in_stall rises while the queue holds three or more results.
// a stalled receiver holds out_data steady; results are never dropped.
// reset (rst_n low, synchronous): line and shot counters clear, the queue
// empties and the registers return to 3, 10 and 10.
module receiver_line_fault_grader #(
  parameter int MAX_LINE_CHANNELS = 4096,
  parameter int MAX_LINES         = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rlfg_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rlfg_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlfg_pkg::ADDR_W-1:0] paddr,
  input  logic [rlfg_pkg::DATA_W-1:0] pwdata,
  output logic [rlfg_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rlfg_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  full;
  logic  accept;

  assign in_stall = full;
  assign accept   = in_valid & !full;

  rlfg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlfg_core #(
    .MAX_LINE_CHANNELS (MAX_LINE_CHANNELS),
    .MAX_LINES         (MAX_LINES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rec    (in_data),
    .cfg    (cfg),
    .push   (push)
  );

  rlfg_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/rlfg_cfg.sv
module rlfg_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlfg_pkg::ADDR_W-1:0] paddr,
  input  logic [rlfg_pkg::DATA_W-1:0] pwdata,
  output logic [rlfg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rlfg_pkg::cfg_t              cfg
);
  import rlfg_pkg::*;

  logic [COUNT_W-1:0] max_bad_run_r;
  logic [PCT_W-1:0]   chan_pct_r;
  logic [PCT_W-1:0]   line_pct_r;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bad_run_r <= RST_MAX_BAD_RUN;
      chan_pct_r    <= RST_MAX_BAD_CHAN_PCT;
      line_pct_r    <= RST_MAX_BAD_LINE_PCT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_BAD_RUN:      max_bad_run_r <= pwdata[COUNT_W-1:0];
        REG_MAX_BAD_CHAN_PCT: chan_pct_r    <= pwdata[PCT_W-1:0];
        REG_MAX_BAD_LINE_PCT: line_pct_r    <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_BAD_RUN:      prdata = DATA_W'(max_bad_run_r);
      REG_MAX_BAD_CHAN_PCT: prdata = DATA_W'(chan_pct_r);
      REG_MAX_BAD_LINE_PCT: prdata = DATA_W'(line_pct_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.max_bad_run      = max_bad_run_r;
  assign cfg.max_bad_chan_pct = chan_pct_r;
  assign cfg.max_bad_line_pct = line_pct_r;

endmodule

// File: rtl/rlfg_core.sv
module rlfg_core #(
  parameter int MAX_LINE_CHANNELS = 4096,
  parameter int MAX_LINES         = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  rlfg_pkg::in_t   rec,
  input  rlfg_pkg::cfg_t  cfg,
  output rlfg_pkg::push_t push
);
  import rlfg_pkg::*;

  localparam int LC_W    = $clog2(MAX_LINE_CHANNELS + 1);
  localparam int LN_W    = $clog2(MAX_LINES + 1);
  localparam int RUN_W   = (LC_W > COUNT_W) ? LC_W : COUNT_W;
  localparam int CPROD_W = LC_W + PCT_W;
  localparam int LPROD_W = LN_W + PCT_W;
  localparam logic [LC_W-1:0] LC_CAP = LC_W'(MAX_LINE_CHANNELS);
  localparam logic [LN_W-1:0] LN_CAP = LN_W'(MAX_LINES);

  logic [LC_W-1:0] bad_run_r, bad_run_nxt;
  logic [LC_W-1:0] bad_total_r, bad_total_nxt;
  logic [LC_W-1:0] chan_total_r, chan_total_nxt;
  logic            run_exc_r, run_exc_nxt;
  logic            has_seis_r, has_seis_nxt;
  logic [LN_W-1:0] failed_r, failed_nxt;
  logic [LN_W-1:0] graded_r, graded_nxt;

  logic            bad, eol, eos;
  logic [LC_W-1:0] run_upd, bad_upd, chan_upd;
  logic            exc_upd, seis_upd;
  logic            share_hit, passed, graded_line;
  logic [LN_W-1:0] failed_upd, graded_upd;
  logic [CPROD_W-1:0] c_lhs, c_rhs;
  logic [LPROD_W-1:0] l_lhs, l_rhs;
  logic [GRADE_W-1:0] grade;

  always_comb begin
    bad  = rec.resistance_fault | rec.tilt_fault | rec.leakage_fault;
    eos  = rec.end_of_shot;
    eol  = rec.end_of_line | rec.end_of_shot;

    chan_upd = (chan_total_r < LC_CAP) ? LC_W'(chan_total_r + 1'b1) : LC_CAP;
    if (bad) begin
      run_upd = (bad_run_r < LC_CAP) ? LC_W'(bad_run_r + 1'b1) : LC_CAP;
      bad_upd = (bad_total_r < LC_CAP) ? LC_W'(bad_total_r + 1'b1) : LC_CAP;
    end else begin
      run_upd = '0;
      bad_upd = bad_total_r;
    end
    exc_upd  = run_exc_r | (RUN_W'(run_upd) > RUN_W'(cfg.max_bad_run));
    seis_upd = has_seis_r | rec.seismic_channel;

    c_lhs = CPROD_W'(bad_upd) * CPROD_W'(PCT_SCALE);
    c_rhs = CPROD_W'(cfg.max_bad_chan_pct) * CPROD_W'(chan_upd);
    share_hit   = c_lhs > c_rhs;
    passed      = !exc_upd && !share_hit;
    graded_line = eol && seis_upd;

    if (graded_line) begin
      graded_upd = (graded_r < LN_CAP) ? LN_W'(graded_r + 1'b1) : LN_CAP;
      failed_upd = (!passed && failed_r < LN_CAP) ? LN_W'(failed_r + 1'b1) : failed_r;
    end else begin
      graded_upd = graded_r;
      failed_upd = failed_r;
    end

    l_lhs = LPROD_W'(failed_upd) * LPROD_W'(PCT_SCALE);
    l_rhs = LPROD_W'(cfg.max_bad_line_pct) * LPROD_W'(graded_upd);
    if (graded_upd == '0) begin
      grade = GRADE_GOOD;
    end else if (l_lhs > l_rhs) begin
      grade = GRADE_BAD;
    end else if (failed_upd != '0) begin
      grade = GRADE_NORMAL;
    end else begin
      grade = GRADE_GOOD;
    end

    push.line_v                   = accept && graded_line;
    push.shot_v                   = accept && eos;
    push.line_res.result_kind     = KIND_LINE;
    push.line_res.line_passed     = passed;
    push.line_res.run_limit_hit   = exc_upd;
    push.line_res.share_limit_hit = share_hit;
    push.line_res.bad_channels    = COUNT_W'(bad_upd);
    push.line_res.line_channels   = COUNT_W'(chan_upd);
    push.line_res.shot_grade      = GRADE_GOOD;
    push.line_res.failed_lines    = SHOT_W'(failed_upd);
    push.line_res.graded_lines    = SHOT_W'(graded_upd);
    push.line_res.last_result     = !eos;
    push.shot_res.result_kind     = KIND_SHOT;
    push.shot_res.line_passed     = 1'b0;
    push.shot_res.run_limit_hit   = 1'b0;
    push.shot_res.share_limit_hit = 1'b0;
    push.shot_res.bad_channels    = '0;
    push.shot_res.line_channels   = '0;
    push.shot_res.shot_grade      = grade;
    push.shot_res.failed_lines    = SHOT_W'(failed_upd);
    push.shot_res.graded_lines    = SHOT_W'(graded_upd);
    push.shot_res.last_result     = 1'b1;

    bad_run_nxt    = bad_run_r;
    bad_total_nxt  = bad_total_r;
    chan_total_nxt = chan_total_r;
    run_exc_nxt    = run_exc_r;
    has_seis_nxt   = has_seis_r;
    failed_nxt     = failed_r;
    graded_nxt     = graded_r;
    if (accept) begin
      if (eol) begin
        bad_run_nxt    = '0;
        bad_total_nxt  = '0;
        chan_total_nxt = '0;
        run_exc_nxt    = 1'b0;
        has_seis_nxt   = 1'b0;
      end else begin
        bad_run_nxt    = run_upd;
        bad_total_nxt  = bad_upd;
        chan_total_nxt = chan_upd;
        run_exc_nxt    = exc_upd;
        has_seis_nxt   = seis_upd;
      end
      if (eos) begin
        failed_nxt = '0;
        graded_nxt = '0;
      end else begin
        failed_nxt = failed_upd;
        graded_nxt = graded_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_run_r    <= '0;
      bad_total_r  <= '0;
      chan_total_r <= '0;
      run_exc_r    <= 1'b0;
      has_seis_r   <= 1'b0;
      failed_r     <= '0;
      graded_r     <= '0;
    end else begin
      bad_run_r    <= bad_run_nxt;
      bad_total_r  <= bad_total_nxt;
      chan_total_r <= chan_total_nxt;
      run_exc_r    <= run_exc_nxt;
      has_seis_r   <= has_seis_nxt;
      failed_r     <= failed_nxt;
      graded_r     <= graded_nxt;
    end
  end

endmodule

// File: rtl/rlfg_outq.sv
module rlfg_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  rlfg_pkg::push_t push,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output rlfg_pkg::out_t  out_data
);
  import rlfg_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] shot_idx;
  logic [1:0]       n_push;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid & !out_stall;
  assign full      = (cnt_r > CNT_W'(DEPTH - 2));

  always_comb begin
    n_push     = 2'(push.line_v) + 2'(push.shot_v);
    shot_idx   = PTR_W'(wr_ptr_r + PTR_W'(push.line_v));
    wr_ptr_nxt = PTR_W'(wr_ptr_r + PTR_W'(n_push));
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CNT_W'(cnt_r + CNT_W'(n_push) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.line_v) begin
      q_r[wr_ptr_r] <= push.line_res;
    end
    if (push.shot_v) begin
      q_r[shot_idx] <= push.shot_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: dv/receiver_line_fault_grader_tb.sv
module receiver_line_fault_grader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlfg_pkg::*;

  localparam int unsigned LINE_CAP    = 4096;
  localparam int unsigned SHOT_CAP    = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 140;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    in_t  rec;
    int   typed_n;
    out_t r0;
    out_t r1;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // grader model state
  logic [COUNT_W-1:0] lim_run      = RST_MAX_BAD_RUN;
  logic [PCT_W-1:0]   lim_chan_pct = RST_MAX_BAD_CHAN_PCT;
  logic [PCT_W-1:0]   lim_line_pct = RST_MAX_BAD_LINE_PCT;
  int unsigned        run_len      = 0;
  int unsigned        bad_cnt      = 0;
  int unsigned        chan_cnt     = 0;
  int unsigned        failed_cnt   = 0;
  int unsigned        graded_cnt   = 0;
  bit                 run_over     = 1'b0;
  bit                 has_seis     = 1'b0;

  out_t        verdict_q[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_left = 0;
  bit          gaps_on    = 1'b1;
  bit          stall_on   = 1'b1;

  receiver_line_fault_grader uut (.*);

  always #4 clk = ~clk;

  function automatic int unsigned sat_inc(input int unsigned v, input int unsigned cap);
    return (v < cap) ? v + 1 : cap;
  endfunction

  function automatic in_t mk_rec(input bit r, input bit t, input bit l, input bit s,
                                 input bit eol, input bit eos);
    in_t x;
    x.resistance_fault = r;
    x.tilt_fault       = t;
    x.leakage_fault    = l;
    x.seismic_channel  = s;
    x.end_of_line      = eol;
    x.end_of_shot      = eos;
    return x;
  endfunction

  function automatic out_t line_res(input bit passed, input bit run_hit, input bit share_hit,
                                    input int unsigned bad, input int unsigned chans,
                                    input int unsigned failed, input int unsigned graded,
                                    input bit last);
    out_t r;
    r = '0;
    r.result_kind     = KIND_LINE;
    r.line_passed     = passed;
    r.run_limit_hit   = run_hit;
    r.share_limit_hit = share_hit;
    r.bad_channels    = bad[COUNT_W-1:0];
    r.line_channels   = chans[COUNT_W-1:0];
    r.shot_grade      = GRADE_GOOD;
    r.failed_lines    = failed[SHOT_W-1:0];
    r.graded_lines    = graded[SHOT_W-1:0];
    r.last_result     = last;
    return r;
  endfunction

  function automatic out_t shot_res(input logic [GRADE_W-1:0] grade,
                                    input int unsigned failed, input int unsigned graded);
    out_t r;
    r = '0;
    r.result_kind  = KIND_SHOT;
    r.shot_grade   = grade;
    r.failed_lines = failed[SHOT_W-1:0];
    r.graded_lines = graded[SHOT_W-1:0];
    r.last_result  = 1'b1;
    return r;
  endfunction

  // counts one channel record and queues the verdicts it produces
  function automatic void grade_record(input in_t rec);
    bit                 bad;
    bit                 share_hit;
    bit                 passed;
    logic [GRADE_W-1:0] grade;
    bad = rec.resistance_fault | rec.tilt_fault | rec.leakage_fault;
    chan_cnt = sat_inc(chan_cnt, LINE_CAP);
    if (bad) begin
      run_len = sat_inc(run_len, LINE_CAP);
      bad_cnt = sat_inc(bad_cnt, LINE_CAP);
    end else begin
      run_len = 0;
    end
    if (run_len > lim_run) run_over = 1'b1;
    if (rec.seismic_channel) has_seis = 1'b1;
    if (rec.end_of_line || rec.end_of_shot) begin
      if (has_seis) begin
        share_hit = (bad_cnt * PCT_SCALE) > (lim_chan_pct * chan_cnt);
        passed = !run_over && !share_hit;
        graded_cnt = sat_inc(graded_cnt, SHOT_CAP);
        if (!passed) failed_cnt = sat_inc(failed_cnt, SHOT_CAP);
        verdict_q.push_back(line_res(passed, run_over, share_hit, bad_cnt, chan_cnt,
                                     failed_cnt, graded_cnt, !rec.end_of_shot));
      end
      run_len  = 0;
      bad_cnt  = 0;
      chan_cnt = 0;
      run_over = 1'b0;
      has_seis = 1'b0;
    end
    if (rec.end_of_shot) begin
      grade = GRADE_GOOD;
      if (graded_cnt != 0) begin
        if ((failed_cnt * PCT_SCALE) > (lim_line_pct * graded_cnt)) grade = GRADE_BAD;
        else if (failed_cnt != 0) grade = GRADE_NORMAL;
      end
      verdict_q.push_back(shot_res(grade, failed_cnt, graded_cnt));
      failed_cnt = 0;
      graded_cnt = 0;
    end
  endfunction

  // typed_n < 0 takes the model's verdicts, otherwise the typed ones replace them
  task automatic send_record(input in_t rec, input int typed_n, input out_t t0, input out_t t1);
    int unsigned gap;
    int unsigned keep_n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    keep_n = verdict_q.size();
    grade_record(rec);
    if (typed_n >= 0) begin
      while (verdict_q.size() > keep_n) void'(verdict_q.pop_back());
      if (typed_n > 0) verdict_q.push_back(t0);
      if (typed_n > 1) verdict_q.push_back(t1);
    end
    @(negedge clk);
  endtask

  task automatic send(input in_t rec);
    send_record(rec, -1, '0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_BAD_RUN:      lim_run      = value[COUNT_W-1:0];
      REG_MAX_BAD_CHAN_PCT: lim_chan_pct = value[PCT_W-1:0];
      REG_MAX_BAD_LINE_PCT: lim_line_pct = value[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // a line with no seismic channel leaves no verdict, so give the pipe time to drain
  task automatic set_limits(input logic [DATA_W-1:0] run_v, input logic [DATA_W-1:0] chan_v,
                            input logic [DATA_W-1:0] line_v);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_MAX_BAD_RUN, run_v);
    write_reg(REG_MAX_BAD_CHAN_PCT, chan_v);
    write_reg(REG_MAX_BAD_LINE_PCT, line_v);
    write_reg(REG_UNUSED, $urandom);
  endtask

  // one well-formed shot with random content, some noise beats mixed in
  task automatic gen_shot();
    int unsigned n_lines;
    int unsigned len;
    int unsigned fault_pct;
    bit          aux_line;
    logic [5:0]  noise;
    in_t         r;
    n_lines = $urandom_range(1, 10);
    for (int unsigned ln = 0; ln < n_lines; ln++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: fault_pct = 0;
        1: fault_pct = 5;
        2: fault_pct = 20;
        default: fault_pct = 60;
      endcase
      aux_line = ($urandom_range(0, 7) == 0);
      for (int unsigned ch = 0; ch < len; ch++) begin
        if ($urandom_range(0, 19) == 0) begin
          noise = $urandom_range(0, 63);
          send(noise);
        end
        r.resistance_fault = ($urandom_range(0, 99) < fault_pct);
        r.tilt_fault       = ($urandom_range(0, 99) < fault_pct);
        r.leakage_fault    = ($urandom_range(0, 99) < fault_pct);
        r.seismic_channel  = aux_line ? 1'b0 : ($urandom_range(0, 5) != 0);
        r.end_of_line      = (ch == len - 1);
        r.end_of_shot      = (ln == n_lines - 1) && (ch == len - 1);
        if (r.end_of_shot) r.end_of_line = $urandom_range(0, 1);
        send(r);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (stall_on && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
      stall_left = 0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", out_data);
      end else begin
        want = verdict_q.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("line_passed", want.line_passed, out_data.line_passed);
        check_field("run_limit_hit", want.run_limit_hit, out_data.run_limit_hit);
        check_field("share_limit_hit", want.share_limit_hit, out_data.share_limit_hit);
        check_field("bad_channels", want.bad_channels, out_data.bad_channels);
        check_field("line_channels", want.line_channels, out_data.line_channels);
        check_field("shot_grade", want.shot_grade, out_data.shot_grade);
        check_field("failed_lines", want.failed_lines, out_data.failed_lines);
        check_field("graded_lines", want.graded_lines, out_data.graded_lines);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned target;

    // directed rows at reset limits: run 3, line share 10, shot share 10
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 1, 1, 0), 1,
                                  line_res(1, 0, 0, 0, 1, 0, 1, 1), '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 1, 0, 1), 2,
                                  line_res(1, 0, 0, 0, 1, 0, 2, 0),
                                  shot_res(GRADE_GOOD, 0, 2)});
    // shot with no graded line
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 0, 0, 1), 1,
                                  shot_res(GRADE_GOOD, 0, 0), '0});
    // auxiliary-only line gives nothing
    dir_rows.push_back(dir_row_t'{mk_rec(1, 1, 1, 0, 1, 0), 0, '0, '0});
    dir_rows.push_back(dir_row_t'{mk_rec(1, 0, 0, 1, 1, 0), 1,
                                  line_res(0, 0, 1, 1, 1, 1, 1, 1), '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 1, 0, 0, 0, 1), 1,
                                  shot_res(GRADE_BAD, 1, 1), '0});
    // run of four bad channels over a limit of three
    repeat (4) dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 1, 1, 0, 0), -1, '0, '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 1, 1, 0), -1, '0, '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 1, 1, 1), -1, '0, '0});
    // one bad in ten sits exactly on the share limit
    dir_rows.push_back(dir_row_t'{mk_rec(1, 0, 0, 1, 0, 0), -1, '0, '0});
    repeat (8) dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 0, 0, 0), -1, '0, '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 0, 1, 0), -1, '0, '0});
    dir_rows.push_back(dir_row_t'{mk_rec(0, 0, 0, 1, 0, 1), -1, '0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_record(dir_rows[i].rec, dir_rows[i].typed_n, dir_rows[i].r0, dir_rows[i].r1);
    end

    // shot counter saturation: a shot with too many lines
    gaps_on = 1'b0;
    set_limits(4096, 99, 50);
    for (int unsigned i = 0; i < SHOT_CAP + 4; i++) begin
      send(mk_rec(0, 1, 0, 1, 1, i == SHOT_CAP + 3));
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_limits(0, 0, 0);
        1: set_limits(4096, 100, 100);
        2: set_limits('1, '1, '1);
        default: set_limits($urandom_range(0, 8), $urandom_range(0, 60),
                            $urandom_range(0, 60));
      endcase
      gaps_on  = (ph % 3 != 2) && (ph != PHASES - 1);
      stall_on = (ph % 3 != 1) && (ph != PHASES - 1);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) gen_shot();
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
